[src/debug_packet_deframer_rle_defines.svh]
// Assertion macros used by the deframer top-level RTL file.
`ifndef DEBUG_PACKET_DEFRAMER_RLE_DEFINES_SVH
`define DEBUG_PACKET_DEFRAMER_RLE_DEFINES_SVH
`ifndef SYNTH
// Implication checked every cycle outside reset.
`define DPDR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
// Next-cycle implication that is also checked during reset.
`define DPDR_ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define DPDR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DPDR_ASSERT_NXT(lbl, clk, ante, cons)
`endif
`endif

[src/dpdrle_pkg.sv]
// Shared types, codes and helpers of the debug packet deframer.
`default_nettype none
package dpdrle_pkg;

  localparam int LenBits = 16;
  // Result fields other than item_kind and last, rounded up to whole bytes.
  localparam int TdataBits = ((LenBits + 34 + 7) / 8) * 8;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DIGIT1  = 2'd2;
  localparam logic [1:0] PH_DIGIT2  = 2'd3;

  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam logic [7:0] CH_START  = 8'h24;
  localparam logic [7:0] CH_END    = 8'h23;
  localparam logic [7:0] CH_RUN    = 8'h2A;
  localparam logic [7:0] COUNT_MIN = 8'd30;
  localparam logic [7:0] COUNT_MAX = 8'd126;
  localparam logic [7:0] COUNT_OFS = 8'd29;

  localparam logic [15:0] MAX_LENGTH_RESET = 16'd2500;

  typedef struct packed {
    logic                 item_kind;
    logic [7:0]           data_byte;
    logic [6:0]           repeat_res;
    logic                 checksum_ok;
    logic [7:0]           received_checksum;
    logic [7:0]           computed_checksum;
    logic [LenBits-1:0]   decoded_length;
    logic                 length_overflow;
    logic                 format_error;
    logic                 last;
  } res_t;

  // Nibble value in the low bits; bit 4 set when the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd0;
    if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h37;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h57;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
    end else begin
      d = 8'd16;
    end
    return d[4:0];
  endfunction

endpackage
`default_nettype wire

[src/dpdrle_parser.sv]
// Packet parser state and the per-byte decode step.
`default_nettype none
module dpdrle_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [7:0]                    in_byte,
  input  wire logic [dpdrle_pkg::LenBits-1:0] max_length,
  output dpdrle_pkg::res_t                   res,
  output logic                               res_emit
);
  import dpdrle_pkg::*;

  logic [1:0]          phase, phase_next;
  logic [7:0]          running_sum, running_sum_next;
  logic [7:0]          previous_byte, previous_byte_next;
  logic                have_previous, have_previous_next;
  logic                expect_count, expect_count_next;
  logic [3:0]          checksum_high, checksum_high_next;
  logic                hex_invalid, hex_invalid_next;
  logic [LenBits-1:0]  length_count, length_count_next;
  logic                overflow_seen, overflow_seen_next;
  logic                format_seen, format_seen_next;

  logic                do_run;
  logic [7:0]          run_value;
  logic [6:0]          run_n;
  logic [LenBits:0]    len_sum;
  logic                run_ovf;
  logic [4:0]          hv;
  logic [7:0]          received;
  logic [7:0]          count_sub;

  always_comb begin
    len_sum   = {1'b0, length_count} + {{(LenBits-6){1'b0}}, run_n};
    run_ovf   = overflow_seen | (len_sum > {1'b0, max_length});
    hv        = hex_value(in_byte);
    count_sub = in_byte - COUNT_OFS;
  end

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    previous_byte_next = previous_byte;
    have_previous_next = have_previous;
    expect_count_next  = expect_count;
    checksum_high_next = checksum_high;
    hex_invalid_next   = hex_invalid;
    length_count_next  = length_count;
    overflow_seen_next = overflow_seen;
    format_seen_next   = format_seen;
    do_run    = 1'b0;
    run_value = in_byte;
    run_n     = 7'd1;
    received  = 8'd0;
    res       = '0;
    res_emit  = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (in_byte == CH_START) begin
          phase_next         = PH_PAYLOAD;
          running_sum_next   = 8'd0;
          previous_byte_next = 8'd0;
          have_previous_next = 1'b0;
          expect_count_next  = 1'b0;
          checksum_high_next = 4'd0;
          hex_invalid_next   = 1'b0;
          length_count_next  = '0;
          overflow_seen_next = 1'b0;
          format_seen_next   = 1'b0;
        end
      end
      PH_PAYLOAD: begin
        if (in_byte == CH_END) begin
          if (expect_count) begin
            format_seen_next = 1'b1;
          end
          expect_count_next = 1'b0;
          phase_next        = PH_DIGIT1;
        end else begin
          running_sum_next = running_sum + in_byte;
          if (expect_count) begin
            expect_count_next = 1'b0;
            if (in_byte < COUNT_MIN || in_byte > COUNT_MAX) begin
              format_seen_next = 1'b1;
            end else if (have_previous) begin
              do_run    = 1'b1;
              run_value = previous_byte;
              run_n     = count_sub[6:0];
            end
          end else if (in_byte == CH_RUN) begin
            if (!have_previous) begin
              format_seen_next = 1'b1;
            end
            expect_count_next = 1'b1;
          end else begin
            previous_byte_next = in_byte;
            have_previous_next = 1'b1;
            do_run             = 1'b1;
          end
        end
      end
      PH_DIGIT1: begin
        hex_invalid_next   = hv[4];
        checksum_high_next = hv[3:0];
        phase_next         = PH_DIGIT2;
      end
      PH_DIGIT2: begin
        received = (hex_invalid || hv[4]) ? 8'd0 : {checksum_high, hv[3:0]};
        phase_next              = PH_IDLE;
        res_emit                = 1'b1;
        res.item_kind           = KIND_END;
        res.checksum_ok         = (received == running_sum);
        res.received_checksum   = received;
        res.computed_checksum   = running_sum;
        res.decoded_length      = length_count;
        res.length_overflow     = overflow_seen;
        res.format_error        = format_seen;
        res.last                = 1'b1;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // Length accounting is shared by plain bytes and expanded runs.
    if (do_run) begin
      length_count_next  = len_sum[LenBits] ? {LenBits{1'b1}} : len_sum[LenBits-1:0];
      overflow_seen_next = run_ovf;
      if (!run_ovf) begin
        res_emit       = 1'b1;
        res.item_kind  = KIND_RUN;
        res.data_byte  = run_value;
        res.repeat_res = run_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      running_sum   <= 8'd0;
      previous_byte <= 8'd0;
      have_previous <= 1'b0;
      expect_count  <= 1'b0;
      checksum_high <= 4'd0;
      hex_invalid   <= 1'b0;
      length_count  <= '0;
      overflow_seen <= 1'b0;
      format_seen   <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      previous_byte <= previous_byte_next;
      have_previous <= have_previous_next;
      expect_count  <= expect_count_next;
      checksum_high <= checksum_high_next;
      hex_invalid   <= hex_invalid_next;
      length_count  <= length_count_next;
      overflow_seen <= overflow_seen_next;
      format_seen   <= format_seen_next;
    end
  end

endmodule
`default_nettype wire

[src/debug_packet_deframer_rle.sv]
// An accepted byte is captured in the input register; its decoded result, if any, is then registered.
// Throughput: one byte per cycle; the only stall comes from m_axis_tready.
// The input register advances whenever the result register is free or drained.
// Reset clears the packet state and both valid flags, and loads max_length
// with 2500; payload registers are not reset.
`default_nettype none
`include "debug_packet_deframer_rle_defines.svh"
module debug_packet_deframer_rle (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [7:0]                          s_axis_tdata,  // rx_byte
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // data_byte, repeat_res, checksum_ok, received_checksum, computed_checksum,
  // decoded_length, length_overflow, format_error, zero fill
  output logic [dpdrle_pkg::TdataBits-1:0]         m_axis_tdata,
  output logic                                     m_axis_tuser,  // item_kind
  output logic                                     m_axis_tlast,  // last
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dpdrle_pkg::LenBits-1:0]      cfg_data       // max_length
);
  import dpdrle_pkg::*;

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               advance;
  logic [LenBits-1:0] max_length;
  res_t               step_res;
  logic               step_emit;
  res_t               out_res;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  dpdrle_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (in_valid && advance),
    .in_byte    (in_byte),
    .max_length (max_length),
    .res        (step_res),
    .res_emit   (step_emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid && step_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && step_emit) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tuser = out_res.item_kind;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tdata = TdataBits'({out_res.format_error, out_res.length_overflow,
                                    out_res.decoded_length, out_res.computed_checksum,
                                    out_res.received_checksum, out_res.checksum_ok,
                                    out_res.repeat_res, out_res.data_byte});

  `DPDR_ASSERT_NXT(a_reset_clears_out, clk, rst, !m_axis_tvalid)
  `DPDR_ASSERT_IMP(a_last_is_status, clk, rst, m_axis_tvalid,
                   m_axis_tlast == (m_axis_tuser == KIND_END))
  `DPDR_ASSERT_IMP(a_run_has_count, clk, rst,
                   m_axis_tvalid && (m_axis_tuser == KIND_RUN),
                   out_res.repeat_res != 7'd0)
  `DPDR_ASSERT_IMP(a_input_waits, clk, rst, in_valid && !advance, !s_axis_tready)

endmodule
`default_nettype wire
